### rtl/avs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avs_pkg: shared constants and types of the ascending value sorter
// Store depth, count widths, queue depth and the word passed from the front
// end to the sorting back end.
// ----------------------------------------------------------------------------
package avs_pkg;

  // Store capacity of one set (range 2 to 64)
  localparam int MAX_ITEMS = 16;
  // Width of a fill count that can hold MAX_ITEMS itself
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  // Width of the data path
  localparam int VAL_W = 32;

  // Decoupling queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Classified word handed from the front end to the back end
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    keep;   // value goes into the store
    logic                    last;   // closes the set, start the run
    logic                    drop;   // some value of this set was discarded
  } word_t;

endpackage

### rtl/avs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avs_front: input classifier
// Counts the values of the current set, marks each word as kept or dropped
// against the store capacity and tracks whether the set overflowed.
// ----------------------------------------------------------------------------
module avs_front
  import avs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic signed [VAL_W-1:0] item_value,
  input  logic                    item_last,
  input  logic                    q_full,
  output logic                    push,
  output word_t                   push_word
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             overflow;
  logic             overflow_next;
  logic             keep;

  // Hold the source while the queue is full
  assign item_stall = q_full;
  assign push       = item_valid && !q_full;

  // Classify against the capacity of the store
  assign keep = (count < CNT_W'(MAX_ITEMS));

  always_comb begin
    push_word.value = item_value;
    push_word.keep  = keep;
    push_word.last  = item_last;
    push_word.drop  = overflow || !keep;
  end

  // Advance the set count, restart it after the last word
  always_comb begin
    count_next    = count;
    overflow_next = overflow;
    if (push) begin
      if (item_last) begin
        count_next    = '0;
        overflow_next = 1'b0;
      end else begin
        if (keep) begin
          count_next = count + CNT_W'(1);
        end
        overflow_next = overflow || !keep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      count    <= count_next;
      overflow <= overflow_next;
    end
  end

endmodule

### rtl/avs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avs_queue: short word queue
// Decouples the classifier from the sorting cells so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
module avs_queue
  import avs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  word_t push_word,
  output logic  full,
  input  logic  pop,
  output word_t pop_word,
  output logic  not_empty
);

  word_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] used;

  assign full      = (used == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (used != '0);
  assign pop_word  = slots[rd_ptr];

  // Write the slot at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   used <= used + QCNT_W'(1);
        2'b01:   used <= used - QCNT_W'(1);
        default: used <= used;
      endcase
    end
  end

endmodule

### rtl/avs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avs_back: sorting cell chain and result output
// A row of compare-and-hold cells keeps the stored values in ascending order
// as they arrive; at the end of a set the row shifts out from its low end
// into the output register.
// ----------------------------------------------------------------------------
module avs_back
  import avs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  word_t                   q_word,
  output logic                    pop,
  output logic                    sorted_valid,
  input  logic                    sorted_stall,
  output logic signed [VAL_W-1:0] sorted_value,
  output logic                    sorted_last,
  output logic                    dropped_flag
);

  typedef enum logic {
    LOAD,
    EMIT
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        fill;
  logic                    drop_hold;
  logic signed [VAL_W-1:0] cells      [MAX_ITEMS];
  logic signed [VAL_W-1:0] ins_next   [MAX_ITEMS];
  logic signed [VAL_W-1:0] shift_next [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]    above;
  logic                    take;
  logic                    out_taken;

  // Pop only while loading a set
  assign pop       = (state == LOAD) && q_valid;
  assign out_taken = sorted_valid && !sorted_stall;
  assign take      = (state == EMIT) && (!sorted_valid || !sorted_stall);

  // Each cell compares the incoming value with what it holds
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    assign above[i] = (CNT_W'(i) >= fill) || (q_word.value < cells[i]);

    if (i == 0) begin : g_head
      assign ins_next[i] = above[i] ? q_word.value : cells[i];
    end else begin : g_body
      assign ins_next[i] = above[i] ? (above[i-1] ? cells[i-1] : q_word.value)
                                    : cells[i];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign shift_next[i] = cells[i];
    end else begin : g_mid
      assign shift_next[i] = cells[i+1];
    end
  end

  // Sequence load and emit, hold the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= LOAD;
      fill         <= '0;
      drop_hold    <= 1'b0;
      sorted_valid <= 1'b0;
    end else begin
      unique case (state)
        LOAD: begin
          if (out_taken) begin
            sorted_valid <= 1'b0;
          end
          if (pop) begin
            if (q_word.keep) begin
              cells <= ins_next;
              fill  <= fill + CNT_W'(1);
            end
            if (q_word.last) begin
              drop_hold <= q_word.drop;
              state     <= EMIT;
            end
          end
        end
        EMIT: begin
          if (take) begin
            sorted_valid <= 1'b1;
            sorted_value <= cells[0];
            sorted_last  <= (fill == CNT_W'(1));
            dropped_flag <= drop_hold;
            cells        <= shift_next;
            fill         <= fill - CNT_W'(1);
            if (fill == CNT_W'(1)) begin
              state <= LOAD;
            end
          end
        end
        default: state <= LOAD;
      endcase
    end
  end

endmodule

### rtl/ascending_value_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascending_value_sorter: top level of the ascending value sorter
// Collects a set of signed values and returns them in ascending order, with
// the greatest flagged as last and an overflow flag on every result.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                   | word
//  --------+-----------+-----------------------------+-----------------------
//  item    | in        | item_valid / item_stall     | item_value, item_last
//  sorted  | out       | sorted_valid / sorted_stall | sorted_value,
//          |           |                             | sorted_last, dropped_flag
//
//  Loading: one word per cycle, while the queue is not full, into a 4-word
//  queue; the cell row inserts one queued word per cycle while loading a set.
//  A set of n stored values (1 <= n <= MAX_ITEMS) drains through the single
//  output register; meanwhile the queue takes up to 4 more words, then the
//  input stalls until the drain ends.
//  Reset clears counts and flags only; the store needs no clearing pass.
//  A stall on the output holds the cell row; a full queue stalls the input.
// ----------------------------------------------------------------------------
module ascending_value_sorter
  import avs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic signed [VAL_W-1:0] item_value,
  input  logic                    item_last,
  output logic                    sorted_valid,
  input  logic                    sorted_stall,
  output logic signed [VAL_W-1:0] sorted_value,
  output logic                    sorted_last,
  output logic                    dropped_flag
);

  logic  push;
  word_t push_word;
  logic  q_full;
  logic  pop;
  word_t pop_word;
  logic  q_valid;

  avs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item_value (item_value),
    .item_last  (item_last),
    .q_full     (q_full),
    .push       (push),
    .push_word  (push_word)
  );

  avs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (q_full),
    .pop       (pop),
    .pop_word  (pop_word),
    .not_empty (q_valid)
  );

  avs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_word       (pop_word),
    .pop          (pop),
    .sorted_valid (sorted_valid),
    .sorted_stall (sorted_stall),
    .sorted_value (sorted_value),
    .sorted_last  (sorted_last),
    .dropped_flag (dropped_flag)
  );

endmodule

### rtl/avs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avs_checker: port-level checks of the ascending value sorter
// Watches the ports over time: ordering within a run, a steady overflow flag
// across a run, no run without a closing input word, and output hold.
// ----------------------------------------------------------------------------
module avs_checker
  import avs_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    item_valid,
  input logic                    item_stall,
  input logic                    item_last,
  input logic                    sorted_valid,
  input logic                    sorted_stall,
  input logic signed [VAL_W-1:0] sorted_value,
  input logic                    sorted_last,
  input logic                    dropped_flag
);

  logic                    in_take;
  logic                    out_take;
  logic                    in_run;
  logic signed [VAL_W-1:0] prev_value;
  logic                    prev_drop;
  logic [3:0]              pending;

  assign in_take  = item_valid && !item_stall;
  assign out_take = sorted_valid && !sorted_stall;

  // Track the run in progress and the sets still owed
  always_ff @(posedge clk) begin
    if (rst) begin
      in_run  <= 1'b0;
      pending <= '0;
    end else begin
      if (out_take) begin
        in_run     <= !sorted_last;
        prev_value <= sorted_value;
        prev_drop  <= dropped_flag;
      end
      case ({in_take && item_last, out_take && sorted_last})
        2'b10:   pending <= pending + 4'd1;
        2'b01:   pending <= pending - 4'd1;
        default: pending <= pending;
      endcase
    end
  end

  // Results of a run come out in ascending order
  a_ascending: assert property (@(posedge clk) disable iff (rst)
    out_take && in_run |-> sorted_value >= prev_value)
    else $error("sorted results out of order");

  // Overflow flag does not change within a run
  a_drop_steady: assert property (@(posedge clk) disable iff (rst)
    out_take && in_run |-> dropped_flag == prev_drop)
    else $error("dropped_flag changed within a run");

  // No result without a closed set
  a_owed: assert property (@(posedge clk) disable iff (rst)
    out_take |-> pending != 4'd0 || (in_take && item_last))
    else $error("result without a closing input word");

  // A stalled result stays valid
  a_hold: assert property (@(posedge clk) disable iff (rst)
    sorted_valid && sorted_stall |=> sorted_valid)
    else $error("sorted_valid dropped while stalled");

endmodule

bind ascending_value_sorter avs_checker u_avs_checker (.*);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the ascending value sorter
// Sends sets of signed words with a last flag and predicts each sorted run
// locally: store up to MAX_ITEMS words, sort ascending at the last word, and
// flag the run if any word of the set was dropped. Every sorted word is
// compared field by field with the oldest prediction. Both sides idle and
// stall at random, with quiet stretches in between.
// ----------------------------------------------------------------------------
module testbench;
  import avs_pkg::*;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    drop;
  } sorted_word_t;

  localparam logic signed [VAL_W-1:0] MIN_VALUE = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] MAX_VALUE = {1'b0, {(VAL_W-1){1'b1}}};
  localparam int TAIL_CYCLES = MAX_ITEMS + QUEUE_DEPTH + 8;

  logic                    clk          = 1'b0;
  logic                    rst          = 1'b1;
  logic                    item_valid   = 1'b0;
  logic                    item_stall;
  logic signed [VAL_W-1:0] item_value   = '0;
  logic                    item_last    = 1'b0;
  logic                    sorted_valid;
  logic                    sorted_stall = 1'b0;
  logic signed [VAL_W-1:0] sorted_value;
  logic                    sorted_last;
  logic                    dropped_flag;

  // Local copy of the set being collected
  logic signed [VAL_W-1:0] set_store [MAX_ITEMS];
  int                      set_fill     = 0;
  logic                    set_overflow = 1'b0;
  sorted_word_t            sorted_queue [$];

  // Idle modes and run statistics
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  int rx_hold = 0;
  int words_sent = 0;
  int sets_closed = 0;
  int overflow_sets = 0;
  int words_checked = 0;
  int mismatches = 0;

  ascending_value_sorter dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item_value   (item_value),
    .item_last    (item_last),
    .sorted_valid (sorted_valid),
    .sorted_stall (sorted_stall),
    .sorted_value (sorted_value),
    .sorted_last  (sorted_last),
    .dropped_flag (dropped_flag)
  );

  always #5 clk = ~clk;

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timeout at %0t", $time);
    $display("Regression FAIL");
    $finish;
  end

  // Collect one accepted word; at the last word sort the set and queue the run
  task automatic absorb_word(input logic signed [VAL_W-1:0] v, input logic l);
    int                      i;
    int                      j;
    logic signed [VAL_W-1:0] key;
    sorted_word_t            w;
    if (set_fill < MAX_ITEMS) begin
      set_store[set_fill] = v;
      set_fill++;
    end else begin
      set_overflow = 1'b1;
    end
    if (l) begin
      for (i = 1; i < set_fill; i++) begin
        key = set_store[i];
        j = i - 1;
        while (j >= 0 && set_store[j] > key) begin
          set_store[j+1] = set_store[j];
          j--;
        end
        set_store[j+1] = key;
      end
      for (i = 0; i < set_fill; i++) begin
        w.value = set_store[i];
        w.last  = (i == set_fill - 1);
        w.drop  = set_overflow;
        sorted_queue.push_back(w);
      end
      sets_closed++;
      if (set_overflow) overflow_sets++;
      set_fill = 0;
      set_overflow = 1'b0;
    end
  endtask

  // Send one word after a random gap; leave valid high for a back-to-back word
  task automatic send_word(input logic signed [VAL_W-1:0] v, input logic l);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item_value <= v;
    item_last  <= l;
    do @(posedge clk); while (item_stall);
    words_sent++;
    absorb_word(v, l);
  endtask

  // Hold the input until every predicted word has come out
  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (sorted_queue.size() != 0);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? MAX_VALUE : MIN_VALUE;
      1: return int'($urandom_range(0, 15)) - 8;
      default: return $urandom();
    endcase
  endfunction

  // Compare one sorted word with the oldest prediction
  task automatic check_word();
    sorted_word_t w;
    if (sorted_queue.size() == 0) begin
      $display("%0t: unexpected word value=%0d last=%0b drop=%0b", $time,
               sorted_value, sorted_last, dropped_flag);
      mismatches++;
    end else begin
      w = sorted_queue.pop_front();
      words_checked++;
      if (sorted_value !== w.value) begin
        $display("%0t: sorted_value expected %0d, got %0d", $time, w.value, sorted_value);
        mismatches++;
      end
      if (sorted_last !== w.last) begin
        $display("%0t: sorted_last expected %0b, got %0b", $time, w.last, sorted_last);
        mismatches++;
      end
      if (dropped_flag !== w.drop) begin
        $display("%0t: dropped_flag expected %0b, got %0b", $time, w.drop, dropped_flag);
        mismatches++;
      end
    end
  endtask

  // Take sorted words and draw a stall before the next one
  always @(posedge clk) begin
    if (rst) begin
      sorted_stall <= 1'b0;
      rx_hold = 0;
    end else begin
      if (sorted_valid && !sorted_stall) begin
        check_word();
        rx_hold = rx_idle ? $urandom_range(0, 9) : 0;
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      sorted_stall <= (rx_hold > 0);
    end
  end

  task automatic test_single_values();
    send_word(MIN_VALUE, 1'b1);
    send_word(MAX_VALUE, 1'b1);
  endtask

  task automatic test_extremes_and_duplicates();
    send_word(MAX_VALUE, 1'b0);
    send_word(0, 1'b0);
    send_word(MIN_VALUE, 1'b0);
    send_word(-1, 1'b0);
    send_word(0, 1'b1);
  endtask

  // Fill the store, then drop the last word itself
  task automatic test_store_overflow();
    int k;
    for (k = 0; k <= MAX_ITEMS; k++)
      send_word((MAX_ITEMS / 2 - k) * 1000003, k == MAX_ITEMS);
    wait_drained();
  endtask

  task automatic test_random_sets();
    int sent;
    int len;
    int k;
    sent = 0;
    while (sent < 140) begin
      if ($urandom_range(0, 3) == 0) tx_idle = !tx_idle;
      if ($urandom_range(0, 3) == 0) rx_idle <= !rx_idle;
      case ($urandom_range(0, 9))
        0: len = MAX_ITEMS;
        1: len = MAX_ITEMS + $urandom_range(1, 4);
        default: len = $urandom_range(1, MAX_ITEMS - 1);
      endcase
      for (k = 0; k < len; k++)
        send_word(pick_value(), k == len - 1);
      sent += len;
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_single_values();
    tx_idle = 1'b1;
    rx_idle <= 1'b1;
    test_extremes_and_duplicates();
    test_store_overflow();
    test_random_sets();

    // Drain and let the pipeline settle
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d words in %0d sets, %0d of them overflowing the store",
             words_sent, sets_closed, overflow_sets);
    $display("Checked %0d sorted words, %0d mismatches", words_checked, mismatches);
    if (mismatches == 0 && sorted_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/avs_pkg.sv
rtl/avs_front.sv
rtl/avs_queue.sv
rtl/avs_back.sv
rtl/ascending_value_sorter.sv
rtl/avs_checker.sv
tb/sv/testbench.sv
